// ----- sv/gray_contrast_gamma_quantizer_assert.svh -----
// Assertion macros for the gray contrast, gamma and quantizer block.
// Included by the top level; the checks compile away under SYNTHESIS.
`ifndef GRAY_CONTRAST_GAMMA_QUANTIZER_ASSERT_SVH
`define GRAY_CONTRAST_GAMMA_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define GCGQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcgq same-cycle check failed");
`define GCGQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcgq next-cycle check failed");
`else
`define GCGQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GCGQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/gcgq_pkg.sv -----
// Shared types and constants of the gray contrast, gamma and quantizer pipeline.
// No dependencies; every module of the block imports this package.
package gcgq_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 9;
    localparam int CFG_INDEX_W     = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CONTRAST_PERCENT  = 2'd0,
        CFG_BRIGHTNESS_OFFSET = 2'd1,
        CFG_GAMMA_ENABLE      = 2'd2,
        CFG_DITHER_ENABLE     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [8:0]        contrast_percent;
        logic signed [8:0] brightness_offset;
        logic              gamma_enable;
        logic              dither_enable;
    } t_cfg;

    localparam logic [8:0]        CONTRAST_RESET   = 9'd135;
    localparam logic signed [8:0] BRIGHTNESS_RESET = 9'sd0;

    localparam int ST_TONE_MUL   = 0;
    localparam int ST_TONE_RECIP = 1;
    localparam int ST_TONE_CLAMP = 2;
    localparam int ST_BRIGHT     = 3;
    localparam int ST_DIV_SETUP  = 4;
    localparam int ST_DIV_FIRST  = 5;
    localparam int DIV_STAGES    = 3;
    localparam int ST_GAMMA      = ST_DIV_FIRST + DIV_STAGES;
    localparam int ST_OUT        = ST_GAMMA + 1;
    localparam int NUM_STAGES    = ST_OUT + 1;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    localparam int DIV_Q_W         = 9;
    localparam int DIV_BITS_PER_ST = DIV_Q_W / DIV_STAGES;

    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam int          RECIP_SHIFT = 23;
    localparam int          QUOT_W      = 11;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MIX   = 32'd1274126177;
    localparam int          HASH_SHIFT = 13;

    localparam logic [7:0] LVL_T1 = 8'd45;
    localparam logic [7:0] LVL_T2 = 8'd70;
    localparam logic [7:0] LVL_T3 = 8'd140;

    localparam logic [1:0] LVL_BLACK = 2'd0;
    localparam logic [1:0] LVL_DARK  = 2'd1;
    localparam logic [1:0] LVL_LIGHT = 2'd2;
    localparam logic [1:0] LVL_WHITE = 2'd3;

endpackage

// ----- sv/gcgq_tone.sv -----
// Contrast and brightness stages: multiply, divide by 100 through a reciprocal,
// clamp, then add the signed offset and clamp. Uses gcgq_pkg.
module gcgq_tone (
    input  logic                 i_clk,
    input  gcgq_pkg::t_stage_en  i_en,
    input  gcgq_pkg::t_cfg       i_cfg,
    input  logic [7:0]           i_gray_in,
    output logic [7:0]           o_gray
);
    import gcgq_pkg::*;

    logic              n_neg;
    logic [7:0]        n_mag;
    logic [16:0]       n_prod;
    logic              r_neg0;
    logic [16:0]       r_prod;
    logic [33:0]       w_recip;
    logic              r_neg1;
    logic [QUOT_W-1:0] r_quot;
    logic [7:0]        n_contrast;
    logic [7:0]        r_contrast;
    logic signed [10:0] w_sum;
    logic [7:0]        n_bright;
    logic [7:0]        r_bright;

    always_comb begin
        n_neg  = !i_gray_in[7];
        n_mag  = i_gray_in[7] ? {1'b0, i_gray_in[6:0]} : 8'd128 - i_gray_in;
        n_prod = 17'(n_mag) * 17'(i_cfg.contrast_percent);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_TONE_MUL]) begin
            r_neg0 <= n_neg;
            r_prod <= n_prod;
        end
    end

    assign w_recip = 34'(r_prod) * 34'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_en[ST_TONE_RECIP]) begin
            r_neg1 <= r_neg0;
            r_quot <= w_recip[RECIP_SHIFT +: QUOT_W];
        end
    end

    always_comb begin
        if (r_quot >= QUOT_W'(128)) begin
            n_contrast = r_neg1 ? 8'd0 : 8'd255;
        end else if (r_neg1) begin
            n_contrast = 8'd128 - r_quot[7:0];
        end else begin
            n_contrast = 8'd128 + r_quot[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_TONE_CLAMP]) begin
            r_contrast <= n_contrast;
        end
    end

    assign w_sum = $signed({3'b000, r_contrast}) + 11'(i_cfg.brightness_offset);

    always_comb begin
        if (w_sum < 11'sd0) begin
            n_bright = 8'd0;
        end else if (w_sum > 11'sd255) begin
            n_bright = 8'd255;
        end else begin
            n_bright = w_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_BRIGHT]) begin
            r_bright <= n_bright;
        end
    end

    assign o_gray = r_bright;

endmodule

// ----- sv/gcgq_hash.sv -----
// Coordinate hash for noise dithering: two multiplies, xor-shift mix, final multiply,
// then a delay line that keeps the threshold aligned with the gray path. Uses gcgq_pkg.
module gcgq_hash #(
    parameter int COORD_WIDTH = gcgq_pkg::COORD_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  gcgq_pkg::t_stage_en     i_en,
    input  logic [COORD_WIDTH-1:0]  i_pixel_x,
    input  logic [COORD_WIDTH-1:0]  i_pixel_y,
    output logic [7:0]              o_thresh
);
    import gcgq_pkg::*;

    logic [31:0] n_px;
    logic [31:0] n_py;
    logic [31:0] r_px;
    logic [31:0] r_py;
    logic [31:0] w_h;
    logic [31:0] r_hx;
    logic [31:0] w_mix;
    logic [7:0]  r_thr [ST_TONE_CLAMP:ST_GAMMA];

    assign n_px = 32'(i_pixel_x) * HASH_MUL_X;
    assign n_py = 32'(i_pixel_y) * HASH_MUL_Y;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_TONE_MUL]) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    assign w_h = r_px + r_py;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_TONE_RECIP]) begin
            r_hx <= w_h ^ (w_h >> HASH_SHIFT);
        end
    end

    assign w_mix = r_hx * HASH_MIX;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_TONE_CLAMP]) begin
            r_thr[ST_TONE_CLAMP] <= w_mix[31:24];
        end
    end

    for (genvar k = ST_TONE_CLAMP + 1; k <= ST_GAMMA; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_thr[k] <= r_thr[k-1];
            end
        end
    end

    assign o_thresh = r_thr[ST_GAMMA];

endmodule

// ----- sv/gcgq_gamma.sv -----
// Square-root gamma: the first Newton step reduces to (g + 255) / 2, the second
// divides g * 255 by it in a three-stage restoring divider. Uses gcgq_pkg.
module gcgq_gamma (
    input  logic                 i_clk,
    input  gcgq_pkg::t_stage_en  i_en,
    input  gcgq_pkg::t_cfg       i_cfg,
    input  logic [7:0]           i_gray,
    output logic [7:0]           o_gray
);
    import gcgq_pkg::*;

    logic [15:0]        w_prod;
    logic [7:0]         r_gray [0:DIV_STAGES];
    logic [7:0]         r_div  [0:DIV_STAGES];
    logic [7:0]         r_rem  [0:DIV_STAGES];
    logic [DIV_Q_W-1:0] r_num  [0:DIV_STAGES];
    logic [DIV_Q_W-1:0] r_quo  [0:DIV_STAGES];
    logic [9:0]         w_sum;
    logic [8:0]         w_root;
    logic [7:0]         n_gamma;
    logic [7:0]         n_out;
    logic [7:0]         r_out;

    assign w_prod = {i_gray, 8'd0} - 16'(i_gray);

    always_ff @(posedge i_clk) begin
        if (i_en[ST_DIV_SETUP]) begin
            r_gray[0] <= i_gray;
            r_div[0]  <= 8'((9'(i_gray) + 9'd255) >> 1);
            r_rem[0]  <= {1'b0, w_prod[15:DIV_Q_W]};
            r_num[0]  <= w_prod[DIV_Q_W-1:0];
            r_quo[0]  <= '0;
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
        logic [7:0]         n_rem;
        logic [DIV_Q_W-1:0] n_num;
        logic [DIV_Q_W-1:0] n_quo;

        always_comb begin
            logic [8:0] v_trial;
            n_rem = r_rem[j-1];
            n_num = r_num[j-1];
            n_quo = r_quo[j-1];
            for (int k = 0; k < DIV_BITS_PER_ST; k++) begin
                v_trial = {n_rem, n_num[DIV_Q_W-1]};
                n_num   = {n_num[DIV_Q_W-2:0], 1'b0};
                if (v_trial >= {1'b0, r_div[j-1]}) begin
                    n_rem = 8'(v_trial - {1'b0, r_div[j-1]});
                    n_quo = {n_quo[DIV_Q_W-2:0], 1'b1};
                end else begin
                    n_rem = v_trial[7:0];
                    n_quo = {n_quo[DIV_Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[ST_DIV_FIRST + j - 1]) begin
                r_gray[j] <= r_gray[j-1];
                r_div[j]  <= r_div[j-1];
                r_rem[j]  <= n_rem;
                r_num[j]  <= n_num;
                r_quo[j]  <= n_quo;
            end
        end
    end

    assign w_sum  = 10'(r_div[DIV_STAGES]) + 10'(r_quo[DIV_STAGES]);
    assign w_root = w_sum[9:1];

    always_comb begin
        if (r_gray[DIV_STAGES] == 8'd0) begin
            n_gamma = 8'd0;
        end else if (w_root > 9'd255) begin
            n_gamma = 8'd255;
        end else begin
            n_gamma = w_root[7:0];
        end
        n_out = i_cfg.gamma_enable ? n_gamma : r_gray[DIV_STAGES];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_GAMMA]) begin
            r_out <= n_out;
        end
    end

    assign o_gray = r_out;

endmodule

// ----- sv/gcgq_quant.sv -----
// Output stage: registers the adjusted gray and its 2-bit level, taken from fixed
// thresholds or from the dither threshold. Uses gcgq_pkg.
module gcgq_quant (
    input  logic                 i_clk,
    input  gcgq_pkg::t_stage_en  i_en,
    input  gcgq_pkg::t_cfg       i_cfg,
    input  logic [7:0]           i_gray,
    input  logic [7:0]           i_thresh,
    output logic [7:0]           o_gray_adjusted,
    output logic [1:0]           o_level
);
    import gcgq_pkg::*;

    logic [9:0]  w_s;
    logic [10:0] w_lo;
    logic [10:0] w_mid;
    logic [10:0] w_hi;
    logic [1:0]  n_fixed;
    logic [1:0]  n_noise;
    logic [7:0]  r_gray;
    logic [1:0]  r_level;

    assign w_s   = {1'b0, i_gray, 1'b0} + 10'(i_gray);
    assign w_lo  = 11'(w_s) + 11'(i_thresh);
    assign w_mid = 11'(w_s - 10'd255) + 11'(i_thresh);
    assign w_hi  = 11'(w_s - 10'd510) + 11'(i_thresh);

    always_comb begin
        if (i_gray < LVL_T1) begin
            n_fixed = LVL_BLACK;
        end else if (i_gray < LVL_T2) begin
            n_fixed = LVL_DARK;
        end else if (i_gray < LVL_T3) begin
            n_fixed = LVL_LIGHT;
        end else begin
            n_fixed = LVL_WHITE;
        end

        if (w_s < 10'd255) begin
            n_noise = (w_lo >= 11'd255) ? LVL_DARK : LVL_BLACK;
        end else if (w_s < 10'd510) begin
            n_noise = (w_mid >= 11'd255) ? LVL_LIGHT : LVL_DARK;
        end else begin
            n_noise = (w_hi >= 11'd255) ? LVL_WHITE : LVL_LIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_OUT]) begin
            r_gray  <= i_gray;
            r_level <= i_cfg.dither_enable ? n_noise : n_fixed;
        end
    end

    assign o_gray_adjusted = r_gray;
    assign o_level         = r_level;

endmodule

// ----- sv/gray_contrast_gamma_quantizer.sv -----
// An accepted word moves through the tone, divider, gamma and output stage registers.
// Throughput: one word per cycle unless stalled; the ten stages each hold their own valid
// bit and advance independently, so a stall at the output only halts the full stages.
// Reset clears all valid bits and loads the register defaults; there is no clearing pass.
// Depends on gcgq_pkg, gcgq_tone, gcgq_hash, gcgq_gamma, gcgq_quant and the assert header.
`include "gray_contrast_gamma_quantizer_assert.svh"
module gray_contrast_gamma_quantizer #(
    parameter int COORD_WIDTH = gcgq_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_gray_in,
    input  logic [COORD_WIDTH-1:0]            i_pixel_x,
    input  logic [COORD_WIDTH-1:0]            i_pixel_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_gray_adjusted,
    output logic [1:0]                        o_level,
    input  logic                              i_cfg_we,
    input  logic [gcgq_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [gcgq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gcgq_pkg::*;

    t_cfg      r_cfg;
    t_stage_en r_vld;
    t_stage_en w_en;
    logic [7:0] w_tone_gray;
    logic [7:0] w_gamma_gray;
    logic [7:0] w_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.contrast_percent  <= CONTRAST_RESET;
            r_cfg.brightness_offset <= BRIGHTNESS_RESET;
            r_cfg.gamma_enable      <= 1'b0;
            r_cfg.dither_enable     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CONTRAST_PERCENT: begin
                    r_cfg.contrast_percent <= i_cfg_data[8:0];
                end
                CFG_BRIGHTNESS_OFFSET: begin
                    r_cfg.brightness_offset <= $signed(i_cfg_data[8:0]);
                end
                CFG_GAMMA_ENABLE: begin
                    r_cfg.gamma_enable <= i_cfg_data[0];
                end
                CFG_DITHER_ENABLE: begin
                    r_cfg.dither_enable <= i_cfg_data[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_vld[ST_OUT];

    gcgq_tone u_tone (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_cfg     (r_cfg),
        .i_gray_in (i_gray_in),
        .o_gray    (w_tone_gray)
    );

    gcgq_hash #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_hash (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .o_thresh  (w_thresh)
    );

    gcgq_gamma u_gamma (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cfg  (r_cfg),
        .i_gray (w_tone_gray),
        .o_gray (w_gamma_gray)
    );

    gcgq_quant u_quant (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_cfg           (r_cfg),
        .i_gray          (w_gamma_gray),
        .i_thresh        (w_thresh),
        .o_gray_adjusted (o_gray_adjusted),
        .o_level         (o_level)
    );

    `GCGQ_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, (&r_vld))
    `GCGQ_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[0])
    `GCGQ_ASSERT_NEXT(a_gamma_to_out, i_clk, i_rst_n, r_vld[ST_GAMMA] && w_en[ST_OUT], o_out_valid)
    `GCGQ_ASSERT_SAME(a_fixed_black, i_clk, i_rst_n, o_out_valid && !r_cfg.dither_enable && (o_gray_adjusted < LVL_T1), o_level == LVL_BLACK)

endmodule
